>>> sv/softened_two_body_leapfrog_step_assert.svh
// assertion macros for the softened two-body leapfrog step
`ifndef SOFTENED_TWO_BODY_LEAPFROG_STEP_ASSERT_SVH
`define SOFTENED_TWO_BODY_LEAPFROG_STEP_ASSERT_SVH

// same-cycle implication
`define STLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/stls_pkg.sv
// shared types, constants and saturation helper for the leapfrog step
`timescale 1ns / 1ps
package stls_pkg;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned MAXW      = 64;
  localparam int unsigned SUMW      = MAXW + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASS_ONE  = 8'd0,
    REG_MASS_TWO  = 8'd1,
    REG_SOFTENING = 8'd2,
    REG_TIME_STEP = 8'd3
  } cfg_reg_e;

  localparam logic [CFG_W-1:0]   MASS_ONE_RST  = 32'd65536;
  localparam logic [CFG_W-1:0]   MASS_TWO_RST  = 32'd65536;
  localparam logic [CFG_W-1:0]   SOFTENING_RST = 32'd0;
  localparam logic [CFG_W-1:0]   TIME_STEP_RST = 32'd655;
  localparam logic [2*CFG_W-1:0] KICK_K_RST    = 64'd42926080;
  localparam logic [2*CFG_W-1:0] SOFT_SQ_RST   = 64'd0;

  // clamp a signed sum to the signed range of w bits
  function automatic logic [MAXW-1:0] sat_word(input logic signed [SUMW-1:0] s,
                                               input int unsigned w);
    logic signed [SUMW-1:0] hi;
    logic signed [SUMW-1:0] lo;
    hi = $signed((SUMW'(1) << (w - 1)) - SUMW'(1));
    lo = -hi - 1;
    if (s > hi) begin
      return MAXW'(hi);
    end else if (s < lo) begin
      return MAXW'(lo);
    end
    return MAXW'(s);
  endfunction

endpackage

>>> sv/softened_two_body_leapfrog_step.sv
// Softened two-body kick-drift-kick leapfrog step, fully pipelined. One body pair is
// accepted every cycle unless a held result stalls the pipeline. Most of the pipeline
// depth lies in the two kick units, each with an SW-stage square root and six W-stage
// restoring dividers, one bit per stage, where W is WORD_WIDTH and SW = max(W,32)+1.
// The user must write configuration on the cfg port only while the pipeline is empty;
// the block itself does not enforce this. cfg_ready_o is always high.
`timescale 1ns / 1ps
module softened_two_body_leapfrog_step import stls_pkg::*; #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // b1_px b1_py b1_pz b1_vx b1_vy b1_vz b2_px b2_py b2_pz b2_vx b2_vy b2_vz
  input  logic [((12*WORD_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // new_b1_px .. new_b1_vz new_b2_px .. new_b2_vz
  output logic [((12*WORD_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                       cfg_index_i,
  input  logic [CFG_W-1:0]                           cfg_data_i
);

  localparam int unsigned W   = WORD_WIDTH;
  localparam int unsigned TDW = ((12*W+7)/8)*8;

  logic [CFG_W-1:0]     mass_one_q, mass_two_q, soft_q, dt_q;
  logic [2*CFG_W-1:0]   k1_q, k2_q, ssq_q;
  logic                 en;
  logic                 ka_vld, dr_vld, kb_vld;
  logic [11:0][W-1:0]   st_in, ka_st, dr_st, kb_st;
  logic                 out_vld_q;
  logic [11:0][W-1:0]   out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_one_q <= MASS_ONE_RST;
      mass_two_q <= MASS_TWO_RST;
      soft_q     <= SOFTENING_RST;
      dt_q       <= TIME_STEP_RST;
      k1_q       <= KICK_K_RST;
      k2_q       <= KICK_K_RST;
      ssq_q      <= SOFT_SQ_RST;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MASS_ONE:  mass_one_q <= cfg_data_i;
          REG_MASS_TWO:  mass_two_q <= cfg_data_i;
          REG_SOFTENING: soft_q     <= cfg_data_i;
          REG_TIME_STEP: dt_q       <= cfg_data_i;
          default:       ;
        endcase
      end
      // body one is pulled by mass two and vice versa
      k1_q  <= (2*CFG_W)'(dt_q) * (2*CFG_W)'(mass_two_q);
      k2_q  <= (2*CFG_W)'(dt_q) * (2*CFG_W)'(mass_one_q);
      ssq_q <= (2*CFG_W)'(soft_q) * (2*CFG_W)'(soft_q);
    end
  end

  assign en            = !kb_vld || !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign st_in         = s_axis_tdata[12*W-1:0];

  stls_kick #(.W(W), .F(FRAC_BITS)) u_kick_a (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid), .st_i(st_in),
    .ssq_i(ssq_q), .k1_i(k1_q), .k2_i(k2_q), .vld_o(ka_vld), .st_o(ka_st)
  );

  stls_drift #(.W(W), .F(FRAC_BITS)) u_drift (
    .clk_i, .rst_ni, .en_i(en), .vld_i(ka_vld), .st_i(ka_st), .dt_i(dt_q),
    .vld_o(dr_vld), .st_o(dr_st)
  );

  stls_kick #(.W(W), .F(FRAC_BITS)) u_kick_b (
    .clk_i, .rst_ni, .en_i(en), .vld_i(dr_vld), .st_i(dr_st),
    .ssq_i(ssq_q), .k1_i(k1_q), .k2_i(k2_q), .vld_o(kb_vld), .st_o(kb_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= kb_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) out_q <= kb_st;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDW'(out_q);

endmodule

>>> sv/stls_kick.sv
// pipelined half-step velocity kick: separation, square root, dividers, saturating update
`timescale 1ns / 1ps
module stls_kick import stls_pkg::*; #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [11:0][W-1:0]   st_i,
  input  logic [2*CFG_W-1:0]   ssq_i,
  input  logic [2*CFG_W-1:0]   k1_i,
  input  logic [2*CFG_W-1:0]   k2_i,
  output logic                 vld_o,
  output logic [11:0][W-1:0]   st_o
);

  localparam int unsigned MW = (W > CFG_W) ? W : CFG_W;
  localparam int unsigned QW = 2 * MW + 2;
  localparam int unsigned SW = MW + 1;
  localparam int unsigned RW = SW + 3;
  localparam int unsigned DW = QW + SW;
  localparam int unsigned KW = 2 * CFG_W;
  localparam int unsigned NU = W + KW;
  localparam int unsigned NW = NU + F - 1;
  localparam int unsigned XW = (NW > DW + W) ? NW : DW + W;
  localparam int unsigned LP = 6 + SW + W;
  localparam int unsigned PW = W + CFG_W;

  logic                  vld_q [LP];
  logic [11:0][W-1:0]    pay_q [LP];
  logic [2:0][W-1:0]     mag_q [3+SW];
  logic [2:0][2*W-1:0]   sq_q;
  logic [QW-1:0]         qln_q [SW+1];
  logic [RW-1:0]         rem_q [SW];
  logic [SW-1:0]         root_q [SW];
  logic [2*SW-1:0]       pl_q;
  logic [2*SW-1:0]       ph_q;
  logic [5:0][PW-1:0]    nlo_q;
  logic [5:0][PW-1:0]    nhi_q;
  logic [DW-1:0]         den_q;
  logic [5:0][NU-1:0]    num_q;
  logic [5:0][XW-1:0]    drem_q [W+1];
  logic [5:0][W-1:0]     dquo_q [W+1];
  logic [5:0]            dovf_q [W+1];
  logic [DW-1:0]         dden_q [W+1];
  logic                  dz_q   [W+1];
  logic                  vld_out_q;
  logic [11:0][W-1:0]    st_out_q;

  logic [2:0][W-1:0]     mag_d;
  logic [2:0][2*W-1:0]   sq_d;
  logic [QW-1:0]         q_d;
  logic [5:0][W-1:0]     mag6;
  logic [5:0][KW-1:0]    k6;
  logic [11:0][W-1:0]    st_d;

  // separation magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [W:0] df;
      df = $signed({st_i[6+i][W-1], st_i[6+i]}) - $signed({st_i[i][W-1], st_i[i]});
      mag_d[i] = df[W] ? W'(-df) : W'(df);
      sq_d[i]  = (2*W)'(mag_q[0][i]) * (2*W)'(mag_q[0][i]);
    end
    q_d = QW'(ssq_i) + QW'(sq_q[0]) + QW'(sq_q[1]) + QW'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LP; s++) vld_q[s] <= 1'b0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int s = 1; s < LP; s++) vld_q[s] <= vld_q[s-1];
      vld_out_q <= vld_q[LP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q[0] <= st_i;
      for (int s = 1; s < LP; s++) pay_q[s] <= pay_q[s-1];
      mag_q[0] <= mag_d;
      for (int s = 1; s < 3 + SW; s++) mag_q[s] <= mag_q[s-1];
      sq_q <= sq_d;
      qln_q[0] <= q_d;
      for (int j = 1; j <= SW; j++) qln_q[j] <= qln_q[j-1];
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    logic [RW-1:0] rem_in;
    logic [SW-1:0] root_in;
    logic [RW-1:0] cand;
    logic [RW-1:0] trial;
    logic          ge;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end
    assign cand  = {rem_in[RW-3:0], qln_q[j][QW-1-2*j -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cand >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? cand - trial : cand;
        root_q[j] <= {root_in[SW-2:0], ge};
      end
    end
  end

  // partial products of the denominator and numerators
  always_comb begin
    for (int n = 0; n < 6; n++) begin
      mag6[n] = mag_q[2+SW][n % 3];
      k6[n]   = (n < 3) ? k1_i : k2_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= (2*SW)'(qln_q[SW][SW-1:0]) * (2*SW)'(root_q[SW-1]);
      ph_q <= (2*SW)'(qln_q[SW][QW-1:SW]) * (2*SW)'(root_q[SW-1]);
      for (int n = 0; n < 6; n++) begin
        nlo_q[n] <= PW'(mag6[n]) * PW'(k6[n][CFG_W-1:0]);
        nhi_q[n] <= PW'(mag6[n]) * PW'(k6[n][KW-1:CFG_W]);
      end
      den_q <= (DW'(ph_q) << SW) + DW'(pl_q);
      for (int n = 0; n < 6; n++) begin
        num_q[n] <= (NU'(nhi_q[n]) << CFG_W) + NU'(nlo_q[n]);
      end
      // range check ahead of the long division
      for (int n = 0; n < 6; n++) begin
        drem_q[0][n] <= XW'(num_q[n]) << (F - 1);
        dquo_q[0][n] <= '0;
        dovf_q[0][n] <= (XW'(num_q[n]) << (F - 1)) >= (XW'(den_q) << W);
      end
      dden_q[0] <= den_q;
      dz_q[0]   <= (den_q == '0);
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 1; k <= W; k++) begin : g_div
    localparam int unsigned B = W - k;
    logic [5:0][XW-1:0] rem_c;
    logic [5:0][W-1:0]  quo_c;
    logic [XW-1:0]      t_c;
    always_comb begin
      t_c = XW'(dden_q[k-1]) << B;
      for (int n = 0; n < 6; n++) begin
        if (drem_q[k-1][n] >= t_c) begin
          rem_c[n] = drem_q[k-1][n] - t_c;
          quo_c[n] = dquo_q[k-1][n] | (W'(1) << B);
        end else begin
          rem_c[n] = drem_q[k-1][n];
          quo_c[n] = dquo_q[k-1][n];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[k] <= rem_c;
        dquo_q[k] <= quo_c;
        dovf_q[k] <= dovf_q[k-1];
        dden_q[k] <= dden_q[k-1];
        dz_q[k]   <= dz_q[k-1];
      end
    end
  end

  // saturating velocity update
  always_comb begin
    st_d = pay_q[LP-1];
    for (int i = 0; i < 3; i++) begin
      logic              neg;
      logic [W:0]        d1;
      logic [W:0]        d2;
      logic signed [W+1:0] a1;
      logic signed [W+1:0] a2;
      logic signed [W+1:0] s1;
      logic signed [W+1:0] s2;
      logic [MAXW-1:0]   r1;
      logic [MAXW-1:0]   r2;
      neg = $signed(pay_q[LP-1][6+i]) < $signed(pay_q[LP-1][i]);
      d1 = dz_q[W] ? '0 : dovf_q[W][i]   ? {1'b1, {W{1'b0}}} : {1'b0, dquo_q[W][i]};
      d2 = dz_q[W] ? '0 : dovf_q[W][3+i] ? {1'b1, {W{1'b0}}} : {1'b0, dquo_q[W][3+i]};
      a1 = {{2{pay_q[LP-1][3+i][W-1]}}, pay_q[LP-1][3+i]};
      a2 = {{2{pay_q[LP-1][9+i][W-1]}}, pay_q[LP-1][9+i]};
      s1 = neg ? a1 - $signed({1'b0, d1}) : a1 + $signed({1'b0, d1});
      s2 = neg ? a2 + $signed({1'b0, d2}) : a2 - $signed({1'b0, d2});
      r1 = sat_word(SUMW'(s1), W);
      r2 = sat_word(SUMW'(s2), W);
      st_d[3+i] = r1[W-1:0];
      st_d[9+i] = r2[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_out_q <= st_d;
  end

  assign vld_o = vld_out_q;
  assign st_o  = st_out_q;

endmodule

>>> sv/stls_drift.sv
// pipelined full-step position drift with saturation
`timescale 1ns / 1ps
module stls_drift import stls_pkg::*; #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [11:0][W-1:0]  st_i,
  input  logic [CFG_W-1:0]    dt_i,
  output logic                vld_o,
  output logic [11:0][W-1:0]  st_o
);

  localparam int unsigned PW = W + CFG_W;

  logic [1:0]            vld_q;
  logic [11:0][W-1:0]    pay_q [2];
  logic [5:0][W-1:0]     av_q;
  logic [5:0][PW-1:0]    prod_q;
  logic                  vld_out_q;
  logic [11:0][W-1:0]    st_out_q;
  logic [5:0][W-1:0]     av_d;
  logic [11:0][W-1:0]    st_d;

  always_comb begin
    for (int n = 0; n < 6; n++) begin
      logic [W-1:0] v;
      v = st_i[(n < 3) ? 3 + n : 6 + n];
      av_d[n] = v[W-1] ? W'(-v) : v;
    end
  end

  always_comb begin
    st_d = pay_q[1];
    for (int n = 0; n < 6; n++) begin
      logic [W:0]          d;
      logic                neg;
      logic signed [W+1:0] a;
      logic signed [W+1:0] s;
      logic [MAXW-1:0]     r;
      int unsigned         pi;
      pi  = (n < 3) ? n : 3 + n;
      neg = pay_q[1][pi+3][W-1];
      d   = ((prod_q[n] >> (F + W)) != '0) ? {1'b1, {W{1'b0}}}
                                           : {1'b0, prod_q[n][F +: W]};
      a   = {{2{pay_q[1][pi][W-1]}}, pay_q[1][pi]};
      s   = neg ? a - $signed({1'b0, d}) : a + $signed({1'b0, d});
      r   = sat_word(SUMW'(s), W);
      st_d[pi] = r[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[0], vld_i};
      vld_out_q <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q[0] <= st_i;
      pay_q[1] <= pay_q[0];
      av_q     <= av_d;
      for (int n = 0; n < 6; n++) prod_q[n] <= PW'(av_q[n]) * PW'(dt_i);
      st_out_q <= st_d;
    end
  end

  assign vld_o = vld_out_q;
  assign st_o  = st_out_q;

endmodule

>>> sv/stls_checker.sv
// port-level checks for the leapfrog step, bound to the top level
`timescale 1ns / 1ps
`include "softened_two_body_leapfrog_step_assert.svh"
module stls_checker #(
  parameter int unsigned TDW = 384
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid,
  input logic           s_axis_tready,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [TDW-1:0] m_axis_tdata
);

  `STLS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `STLS_ASSERT_NOW(a_ready_blocked, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a blocked result")
  `STLS_ASSERT_NEXT(a_block_keeps, !s_axis_tready && !s_axis_tvalid, m_axis_tvalid, "blocked result vanished")

endmodule

bind softened_two_body_leapfrog_step stls_checker #(.TDW($bits(m_axis_tdata))) u_stls_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);
